>>> design/adpu_pkg.sv
// adpu_pkg: shared types, constants and helpers for the adaptive parameter update block
// used by adpu_mul, adpu_div and adaptive_dynamic_param_update_top
`timescale 1ns / 1ps
package adpu_pkg;

  localparam int WORD_W     = 64;
  localparam int PARAM_W    = 48;
  localparam int GAIN_W     = 47;
  localparam int NUM_PARAMS = 6;
  localparam int IDX_W      = 3;
  localparam int X2_W       = 20;
  localparam int TH_W       = 18;

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [PARAM_W-1:0] param_t;
  typedef logic [GAIN_W-1:0]         gain_t;

  localparam word_t K_G        = 64'sd642253;
  localparam word_t KU1_Q16    = 64'sd39322;
  localparam word_t KW1_Q16    = 64'sd96338;
  localparam word_t KW2_Q16    = 64'sd89165;
  localparam word_t TANH_ONE   = 64'sd65536;
  localparam word_t TANH_LIMIT = 64'sd196608;
  localparam word_t TANH_C27   = 64'sd1769472;
  localparam word_t EPS_U_RAW  = 64'sd327;
  localparam word_t EPS_W_RAW  = 64'sd655;
  localparam word_t MASS_MIN   = 64'sd65;
  localparam word_t TS_Q40     = 64'sd10995116278;
  localparam logic [WORD_W-1:0] SAT_MAG = 64'h2000_0000_0000_0000;

  localparam word_t P_MAX = 64'sd140737488355327;
  localparam word_t P_MIN = -64'sd140737488355328;

  localparam logic [IDX_W-1:0] REG_ADAPT_GAIN = 3'd6;
  localparam logic [IDX_W-1:0] REG_LEAK_GAIN  = 3'd7;

  localparam param_t NOM_P1_RST = 48'sd266191765085;
  localparam param_t NOM_P2_RST = 48'sd306983646475;
  localparam param_t NOM_P3_RST = -48'sd1429365116;
  localparam param_t NOM_P4_RST = 48'sd1099621578939;
  localparam param_t NOM_P5_RST = 48'sd300716430197;
  localparam param_t NOM_P6_RST = 48'sd1047724630108;
  localparam gain_t  GAIN_RST   = 47'd1099511627776;
  localparam gain_t  LEAK_RST   = 47'd109951163;

  typedef enum logic [1:0] {SH0, SH8, SH16, SH40} shift_t;

  typedef struct packed {
    logic   start;
    shift_t sh;
  } mul_req_t;

  typedef enum logic [4:0] {
    ST_NU1, ST_NU2, ST_AU, ST_NW1, ST_NW2, ST_AW, ST_XW,
    ST_TU_X2, ST_TU_NUM, ST_TU_DIV, ST_S1,
    ST_TW_X2, ST_TW_NUM, ST_TW_DIV, ST_S2,
    ST_W2, ST_UW, ST_GRAD, ST_LEAK, ST_RATE, ST_UPD
  } step_t;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_MWAIT, S_DWAIT, S_OUT} top_st_t;

  function automatic param_t sat_param(input word_t v);
    param_t r;
    if (v > P_MAX) r = P_MAX[PARAM_W-1:0];
    else if (v < P_MIN) r = P_MIN[PARAM_W-1:0];
    else r = v[PARAM_W-1:0];
    return r;
  endfunction

  function automatic word_t abs_w(input word_t v);
    word_t r;
    r = v[WORD_W-1] ? -v : v;
    return r;
  endfunction

endpackage

>>> design/adpu_mul.sv
// adpu_mul: shared 64x64 signed multiplier, one 32x32 partial product per cycle
// truncates toward zero after a per-request shift and saturates to 62 bits; uses adpu_pkg
`timescale 1ns / 1ps
module adpu_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  adpu_pkg::mul_req_t req_i,
  input  adpu_pkg::word_t   a_i,
  input  adpu_pkg::word_t   b_i,
  output logic              done_o,
  output adpu_pkg::word_t   res_o
);

  logic [63:0]            ma_r, mb_r;
  logic                   neg_r;
  adpu_pkg::shift_t       sh_r;
  logic [127:0]           acc_r;
  logic [1:0]             cnt_r;
  logic                   busy_r, fin_r, done_r;
  adpu_pkg::word_t        res_r;

  logic [31:0]            ah, bh;
  logic [63:0]            pp;
  logic [127:0]           pp_sh, shifted;
  logic [63:0]            lim, mag;
  adpu_pkg::word_t        res_nxt;

  assign ah    = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign bh    = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp    = ah * bh;
  assign pp_sh = {64'd0, pp} << {({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]}), 5'd0};

  always_comb begin
    case (sh_r)
      adpu_pkg::SH0:  shifted = acc_r;
      adpu_pkg::SH8:  shifted = acc_r >> 8;
      adpu_pkg::SH16: shifted = acc_r >> 16;
      adpu_pkg::SH40: shifted = acc_r >> 40;
      default:        shifted = acc_r;
    endcase
    lim = neg_r ? adpu_pkg::SAT_MAG : adpu_pkg::SAT_MAG - 64'd1;
    mag = (shifted[127:64] != 64'd0 || shifted[63:0] > lim) ? lim : shifted[63:0];
    res_nxt = neg_r ? -adpu_pkg::word_t'(mag) : adpu_pkg::word_t'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        ma_r   <= adpu_pkg::abs_w(a_i);
        mb_r   <= adpu_pkg::abs_w(b_i);
        neg_r  <= a_i[63] ^ b_i[63];
        sh_r   <= req_i.sh;
        acc_r  <= 128'd0;
        cnt_r  <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + pp_sh;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= res_nxt;
      end
    end
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule

>>> design/adpu_div.sv
// adpu_div: radix-2 restoring divider, signed 64-bit dividend by positive divisor
// quotient truncated toward zero, one bit per cycle; uses adpu_pkg
`timescale 1ns / 1ps
module adpu_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start_i,
  input  adpu_pkg::word_t dividend_i,
  input  logic [63:0]     divisor_i,
  output logic            done_o,
  output adpu_pkg::word_t quot_o
);

  logic [63:0] rem_r, quo_r, dsr_r;
  logic        neg_r, busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [64:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        rem_r  <= 64'd0;
        quo_r  <= adpu_pkg::abs_w(dividend_i);
        dsr_r  <= divisor_i;
        neg_r  <= dividend_i[63];
        cnt_r  <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[63:0] : rem_sh[63:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = neg_r ? -adpu_pkg::word_t'(quo_r) : adpu_pkg::word_t'(quo_r);

endmodule

>>> design/adaptive_dynamic_param_update_top.sv
// adaptive_dynamic_param_update_top: sequencer, register file and ports of the estimator
// depends on adpu_pkg, adpu_mul, adpu_div
//
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata (speeds, force, torque, masses, dampings, enable)
// out_    | out | out_tvalid / out_tready   | out_tdata (est_p1..est_p6)
// cfg_    | in  | cfg_wr_en                 | cfg_addr, cfg_wdata
//
// fast paths (small mass, disabled, deadzone) bypass the multiplier and the divider
// a full update makes 37 passes through the multiplier and 4 divides,
// besides the accept, check and output load steps
// a saturated tanh argument skips two multiplier passes and a divide
// in_tready is high only when the sequencer is idle; one result waits in the output register
// synchronous active-low reset restores nominal registers, gains and parameters
`timescale 1ns / 1ps
module adaptive_dynamic_param_update_top #(
  parameter int DATA_WIDTH = 32,
  localparam int IN_TDATA_W = ((10 * DATA_WIDTH + 1 + 7) / 8) * 8,
  localparam int OUT_TDATA_W = adpu_pkg::NUM_PARAMS * adpu_pkg::PARAM_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // lin_speed, ang_speed, push_force, twist_torque, ref_lin_speed, ref_ang_speed,
  // lin_mass, lin_damping, ang_mass, ang_damping, adapt_on, zero fill
  input  logic [IN_TDATA_W-1:0]      in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // est_p1, est_p2, est_p3, est_p4, est_p5, est_p6
  output logic [OUT_TDATA_W-1:0]     out_tdata,
  input  logic                       cfg_wr_en,
  input  logic [adpu_pkg::IDX_W-1:0] cfg_addr,
  input  logic [adpu_pkg::PARAM_W-1:0] cfg_wdata
);

  localparam int DW = DATA_WIDTH;

  adpu_pkg::top_st_t st_r, st_nxt;
  adpu_pkg::step_t   step_r, step_nxt;
  logic [adpu_pkg::IDX_W-1:0] idx_r, idx_nxt;

  adpu_pkg::param_t nom_r [adpu_pkg::NUM_PARAMS];
  adpu_pkg::param_t p_r   [adpu_pkg::NUM_PARAMS];
  adpu_pkg::gain_t  gain_r, leak_r;
  logic             prev_en_r, en_r;

  adpu_pkg::word_t u_r, w_r, fr_r, tr_r, mu_r, du_r, mw_r, dw_r, ut_r, wt_r;
  adpu_pkg::word_t t1_r, num_r, accu_r, accw_r, xw_r, w2_r, uw_r, g_r, d_r;
  logic [adpu_pkg::X2_W-1:0] x2_r;
  logic signed [adpu_pkg::TH_W-1:0] th_r;

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_valid_r;

  adpu_pkg::mul_req_t mul_req;
  logic               mul_start;
  adpu_pkg::shift_t   mul_sh;
  adpu_pkg::word_t    mul_a, mul_b, mul_res, div_q, div_num;
  logic [63:0]        div_den;
  logic               mul_done, div_done, div_start;
  logic               accept, out_load, skip, is_div, tanh_sat, wb, small_mass, dead;
  adpu_pkg::word_t    xu, magu, magw, den, tanh_x;

  assign accept = in_tvalid && in_tready;
  assign xu     = (ut_r <<< 2) + ut_r;
  assign magu   = adpu_pkg::abs_w(xu);
  assign magw   = adpu_pkg::abs_w(xw_r);
  assign den    = adpu_pkg::TANH_C27 + adpu_pkg::word_t'({x2_r, 3'b000}) +
                  adpu_pkg::word_t'(x2_r);
  assign small_mass = (mu_r <= adpu_pkg::MASS_MIN) || (mw_r <= adpu_pkg::MASS_MIN);
  assign dead   = !(adpu_pkg::abs_w(ut_r) > adpu_pkg::EPS_U_RAW ||
                    adpu_pkg::abs_w(wt_r) > adpu_pkg::EPS_W_RAW);
  assign is_div = (step_r == adpu_pkg::ST_AU) || (step_r == adpu_pkg::ST_AW) ||
                  (step_r == adpu_pkg::ST_TU_DIV) || (step_r == adpu_pkg::ST_TW_DIV);
  assign tanh_sat = (step_r == adpu_pkg::ST_TU_X2 && magu >= adpu_pkg::TANH_LIMIT) ||
                    (step_r == adpu_pkg::ST_TW_X2 && magw >= adpu_pkg::TANH_LIMIT);
  assign tanh_x = (step_r == adpu_pkg::ST_TU_X2) ? xu : xw_r;
  assign wb     = (st_r == adpu_pkg::S_MWAIT && mul_done) ||
                  (st_r == adpu_pkg::S_DWAIT && div_done);
  assign mul_req = adpu_pkg::mul_req_t'{start: mul_start, sh: mul_sh};

  // control outputs
  always_comb begin
    in_tready = (st_r == adpu_pkg::S_IDLE);
    mul_start = (st_r == adpu_pkg::S_ISSUE) && !is_div && !tanh_sat;
    div_start = (st_r == adpu_pkg::S_ISSUE) && is_div;
    skip      = (st_r == adpu_pkg::S_ISSUE) && tanh_sat;
    out_load  = (st_r == adpu_pkg::S_OUT) && (!out_valid_r || out_tready);
  end

  // next state
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    idx_nxt  = idx_r;
    case (st_r)
      adpu_pkg::S_IDLE: begin
        if (in_tvalid) st_nxt = adpu_pkg::S_CHECK;
      end
      adpu_pkg::S_CHECK: begin
        if (small_mass) st_nxt = adpu_pkg::S_IDLE;
        else if (!en_r || dead) st_nxt = adpu_pkg::S_OUT;
        else begin
          st_nxt   = adpu_pkg::S_ISSUE;
          step_nxt = adpu_pkg::ST_NU1;
          idx_nxt  = '0;
        end
      end
      adpu_pkg::S_ISSUE: begin
        if (skip) step_nxt = adpu_pkg::step_t'(step_r + 5'd3);
        else if (is_div) st_nxt = adpu_pkg::S_DWAIT;
        else st_nxt = adpu_pkg::S_MWAIT;
      end
      adpu_pkg::S_MWAIT, adpu_pkg::S_DWAIT: begin
        if (wb) begin
          st_nxt = adpu_pkg::S_ISSUE;
          if (step_r == adpu_pkg::ST_UPD) begin
            if (idx_r == 3'(adpu_pkg::NUM_PARAMS - 1)) st_nxt = adpu_pkg::S_OUT;
            else begin
              idx_nxt  = idx_r + 3'd1;
              step_nxt = adpu_pkg::ST_GRAD;
            end
          end else begin
            step_nxt = adpu_pkg::step_t'(step_r + 5'd1);
          end
        end
      end
      adpu_pkg::S_OUT: begin
        if (out_load) st_nxt = adpu_pkg::S_IDLE;
      end
      default: st_nxt = adpu_pkg::S_IDLE;
    endcase
  end

  // operand selection for the shared units
  always_comb begin
    mul_a  = u_r;
    mul_b  = w_r;
    mul_sh = adpu_pkg::SH0;
    case (step_r)
      adpu_pkg::ST_NU1: begin mul_a = fr_r; mul_b = adpu_pkg::K_G; end
      adpu_pkg::ST_NU2: begin mul_a = du_r; mul_b = u_r; end
      adpu_pkg::ST_NW1: begin mul_a = -tr_r; mul_b = adpu_pkg::K_G; end
      adpu_pkg::ST_NW2: begin mul_a = dw_r; mul_b = w_r; end
      adpu_pkg::ST_XW: begin
        mul_a = wt_r; mul_b = adpu_pkg::KW2_Q16; mul_sh = adpu_pkg::SH16;
      end
      adpu_pkg::ST_TU_X2: begin mul_a = magu; mul_b = magu; mul_sh = adpu_pkg::SH16; end
      adpu_pkg::ST_TU_NUM: begin
        mul_a = magu; mul_b = adpu_pkg::TANH_C27 + adpu_pkg::word_t'(x2_r);
      end
      adpu_pkg::ST_S1: begin
        mul_a = adpu_pkg::KU1_Q16; mul_b = adpu_pkg::word_t'(th_r); mul_sh = adpu_pkg::SH16;
      end
      adpu_pkg::ST_TW_X2: begin mul_a = magw; mul_b = magw; mul_sh = adpu_pkg::SH16; end
      adpu_pkg::ST_TW_NUM: begin
        mul_a = magw; mul_b = adpu_pkg::TANH_C27 + adpu_pkg::word_t'(x2_r);
      end
      adpu_pkg::ST_S2: begin
        mul_a = adpu_pkg::KW1_Q16; mul_b = adpu_pkg::word_t'(th_r); mul_sh = adpu_pkg::SH16;
      end
      adpu_pkg::ST_W2: begin mul_a = w_r; mul_b = w_r; end
      adpu_pkg::ST_UW: begin mul_a = u_r; mul_b = w_r; end
      adpu_pkg::ST_GRAD: begin
        case (idx_r)
          3'd0: begin mul_a = accu_r; mul_b = ut_r <<< 8; end
          3'd1: begin mul_a = accw_r; mul_b = wt_r <<< 8; end
          3'd2: begin mul_a = w2_r; mul_b = ut_r; mul_sh = adpu_pkg::SH8; end
          3'd3: begin mul_a = u_r; mul_b = ut_r <<< 8; end
          3'd4: begin mul_a = uw_r; mul_b = wt_r; mul_sh = adpu_pkg::SH8; end
          default: begin mul_a = w_r; mul_b = wt_r <<< 8; end
        endcase
      end
      adpu_pkg::ST_LEAK: begin
        mul_a = adpu_pkg::word_t'(leak_r); mul_b = adpu_pkg::word_t'(p_r[idx_r]);
        mul_sh = adpu_pkg::SH40;
      end
      adpu_pkg::ST_RATE: begin
        mul_a = adpu_pkg::word_t'(gain_r); mul_b = d_r; mul_sh = adpu_pkg::SH40;
      end
      adpu_pkg::ST_UPD: begin
        mul_a = t1_r; mul_b = adpu_pkg::TS_Q40; mul_sh = adpu_pkg::SH40;
      end
      default: begin mul_a = u_r; mul_b = w_r; end
    endcase
  end

  always_comb begin
    div_num = num_r;
    case (step_r)
      adpu_pkg::ST_AU: div_den = mu_r;
      adpu_pkg::ST_AW: div_den = mw_r;
      default:         div_den = den;
    endcase
  end

  adpu_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  adpu_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= adpu_pkg::S_IDLE;
      step_r <= adpu_pkg::ST_NU1;
      idx_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // configuration, enable and parameter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r[0]  <= adpu_pkg::NOM_P1_RST;
      nom_r[1]  <= adpu_pkg::NOM_P2_RST;
      nom_r[2]  <= adpu_pkg::NOM_P3_RST;
      nom_r[3]  <= adpu_pkg::NOM_P4_RST;
      nom_r[4]  <= adpu_pkg::NOM_P5_RST;
      nom_r[5]  <= adpu_pkg::NOM_P6_RST;
      p_r[0]    <= adpu_pkg::NOM_P1_RST;
      p_r[1]    <= adpu_pkg::NOM_P2_RST;
      p_r[2]    <= adpu_pkg::NOM_P3_RST;
      p_r[3]    <= adpu_pkg::NOM_P4_RST;
      p_r[4]    <= adpu_pkg::NOM_P5_RST;
      p_r[5]    <= adpu_pkg::NOM_P6_RST;
      gain_r    <= adpu_pkg::GAIN_RST;
      leak_r    <= adpu_pkg::LEAK_RST;
      prev_en_r <= 1'b0;
      en_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr < 3'(adpu_pkg::NUM_PARAMS)) nom_r[cfg_addr] <= cfg_wdata;
        else if (cfg_addr == adpu_pkg::REG_ADAPT_GAIN)
          gain_r <= cfg_wdata[adpu_pkg::GAIN_W-1:0];
        else if (cfg_addr == adpu_pkg::REG_LEAK_GAIN)
          leak_r <= cfg_wdata[adpu_pkg::GAIN_W-1:0];
      end
      if (accept) begin
        en_r      <= in_tdata[10*DW];
        prev_en_r <= in_tdata[10*DW];
        if (in_tdata[10*DW] != prev_en_r) begin
          for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++) p_r[i] <= nom_r[i];
        end
      end
      if (st_r == adpu_pkg::S_CHECK && !small_mass && !en_r) begin
        for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++) p_r[i] <= nom_r[i];
      end
      if (wb && step_r == adpu_pkg::ST_UPD) begin
        p_r[idx_r] <= adpu_pkg::sat_param(adpu_pkg::word_t'(p_r[idx_r]) + mul_res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u_r  <= 64'(signed'(in_tdata[0*DW +: DW]));
      w_r  <= 64'(signed'(in_tdata[1*DW +: DW]));
      fr_r <= 64'(signed'(in_tdata[2*DW +: DW]));
      tr_r <= 64'(signed'(in_tdata[3*DW +: DW]));
      ut_r <= 64'(signed'(in_tdata[4*DW +: DW])) - 64'(signed'(in_tdata[0*DW +: DW]));
      wt_r <= 64'(signed'(in_tdata[5*DW +: DW])) - 64'(signed'(in_tdata[1*DW +: DW]));
      mu_r <= 64'(signed'(in_tdata[6*DW +: DW]));
      du_r <= 64'(signed'(in_tdata[7*DW +: DW]));
      mw_r <= 64'(signed'(in_tdata[8*DW +: DW]));
      dw_r <= 64'(signed'(in_tdata[9*DW +: DW]));
    end
    if (skip) begin
      th_r <= tanh_x[63] ? -adpu_pkg::TANH_ONE[adpu_pkg::TH_W-1:0]
                         : adpu_pkg::TANH_ONE[adpu_pkg::TH_W-1:0];
    end
    if (wb) begin
      case (step_r)
        adpu_pkg::ST_NU1, adpu_pkg::ST_NW1: t1_r <= mul_res;
        adpu_pkg::ST_NU2, adpu_pkg::ST_NW2: num_r <= t1_r - mul_res;
        adpu_pkg::ST_AU: accu_r <= div_q;
        adpu_pkg::ST_AW: accw_r <= div_q;
        adpu_pkg::ST_XW: xw_r <= mul_res;
        adpu_pkg::ST_TU_X2, adpu_pkg::ST_TW_X2: x2_r <= mul_res[adpu_pkg::X2_W-1:0];
        adpu_pkg::ST_TU_NUM, adpu_pkg::ST_TW_NUM: num_r <= mul_res;
        adpu_pkg::ST_TU_DIV:
          th_r <= xu[63] ? -div_q[adpu_pkg::TH_W-1:0] : div_q[adpu_pkg::TH_W-1:0];
        adpu_pkg::ST_TW_DIV:
          th_r <= xw_r[63] ? -div_q[adpu_pkg::TH_W-1:0] : div_q[adpu_pkg::TH_W-1:0];
        adpu_pkg::ST_S1: accu_r <= accu_r + mul_res;
        adpu_pkg::ST_S2: accw_r <= accw_r + mul_res;
        adpu_pkg::ST_W2: w2_r <= mul_res;
        adpu_pkg::ST_UW: uw_r <= mul_res;
        adpu_pkg::ST_GRAD: g_r <= (idx_r == 3'd2) ? -mul_res : mul_res;
        adpu_pkg::ST_LEAK: d_r <= g_r - mul_res;
        adpu_pkg::ST_RATE: t1_r <= mul_res;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++)
        out_data_r[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W] <= p_r[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && div_start))
    else $error("multiplier and divider started together");
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> st_r == adpu_pkg::S_CHECK)
    else $error("accepted transfer not checked next cycle");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == adpu_pkg::S_ISSUE |-> idx_r < 3'(adpu_pkg::NUM_PARAMS))
    else $error("parameter index out of range");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before transfer");
`endif

endmodule

>>> dv/tb_adaptive_dynamic_param_update_top.sv
// tb_adaptive_dynamic_param_update_top: self-checking testbench of the adaptive parameter estimator
// drives random and directed ticks and configuration writes, predicts the six estimates
// depends on adpu_pkg and adaptive_dynamic_param_update_top
`timescale 1ns / 1ps
module tb_adaptive_dynamic_param_update_top;

  localparam int DW = 32;
  localparam int IN_W = ((10 * DW + 1 + 7) / 8) * 8;
  localparam int OUT_W = adpu_pkg::NUM_PARAMS * adpu_pkg::PARAM_W;
  localparam int SATW = 62;

  localparam logic [adpu_pkg::IDX_W-1:0] REG_NOM_P1 = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [adpu_pkg::IDX_W-1:0] cfg_addr = '0;
  logic [adpu_pkg::PARAM_W-1:0] cfg_wdata = '0;

  adaptive_dynamic_param_update_top #(.DATA_WIDTH(DW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic signed [DW-1:0] lin_speed, ang_speed, push_force, twist_torque;
    logic signed [DW-1:0] ref_lin, ref_ang, lin_mass, lin_damp, ang_mass, ang_damp;
    logic adapt_on;
  } tick_t;

  longint nom[adpu_pkg::NUM_PARAMS];
  longint est[adpu_pkg::NUM_PARAMS];
  longint gain_q, leak_q;
  bit prev_en;
  logic [OUT_W-1:0] est_queue[$];
  int errors = 0;
  bit rx_stall_en = 1'b1;
  bit tx_gap_en = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_off = 0;

  // trunc(a*b >> sh) toward zero, saturated to 62-bit signed
  function automatic longint mul_trunc(longint a, longint b, int sh);
    logic signed [129:0] p;
    logic [129:0] m;
    logic [129:0] lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 130'(signed'(a)) * 130'(signed'(b));
    m = p[129] ? -p : p;
    m = m >> sh;
    lim = (130'(1) << (SATW - 1)) - (neg ? 0 : 1);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint tanh_approx(longint x);
    longint mag, r, x2;
    mag = x < 0 ? -x : x;
    if (mag >= 196608) r = 65536;
    else begin
      x2 = (mag * mag) >>> 16;
      r = (mag * (27 * 65536 + x2)) / (27 * 65536 + 9 * x2);
    end
    return x < 0 ? -r : r;
  endfunction

  function automatic longint sat48(longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  task automatic estimate_update(tick_t t);
    longint u, w, ut, wt, nu, nw, s1, s2, w2, uw, d, rate;
    longint grad[adpu_pkg::NUM_PARAMS];
    logic [OUT_W-1:0] r;
    u = t.lin_speed; w = t.ang_speed;
    if (t.adapt_on != prev_en) est = nom;
    prev_en = t.adapt_on;
    if (longint'(t.lin_mass) <= 65 || longint'(t.ang_mass) <= 65) return;
    if (!t.adapt_on) est = nom;
    else begin
      ut = longint'(t.ref_lin) - u;
      wt = longint'(t.ref_ang) - w;
      if ((ut < 0 ? -ut : ut) > 327 || (wt < 0 ? -wt : wt) > 655) begin
        nu = mul_trunc(t.push_force, 642253, 0) - mul_trunc(t.lin_damp, u, 0);
        nw = mul_trunc(-longint'(t.twist_torque), 642253, 0) - mul_trunc(t.ang_damp, w, 0);
        s1 = nu / longint'(t.lin_mass) + mul_trunc(39322, tanh_approx(ut * 5), 16);
        s2 = nw / longint'(t.ang_mass)
             + mul_trunc(96338, tanh_approx(mul_trunc(wt, 89165, 16)), 16);
        w2 = mul_trunc(w, w, 0);
        uw = mul_trunc(u, w, 0);
        grad[0] = mul_trunc(s1, ut * 256, 0);
        grad[1] = mul_trunc(s2, wt * 256, 0);
        grad[2] = -mul_trunc(w2, ut, 8);
        grad[3] = mul_trunc(u, ut * 256, 0);
        grad[4] = mul_trunc(uw, wt, 8);
        grad[5] = mul_trunc(w, wt * 256, 0);
        for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++) begin
          d = grad[i] - mul_trunc(leak_q, est[i], 40);
          rate = mul_trunc(gain_q, d, 40);
          est[i] = sat48(est[i] + mul_trunc(rate, 64'sd10995116278, 40));
        end
      end
    end
    for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++)
      r[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W] = est[i][adpu_pkg::PARAM_W-1:0];
    est_queue = {est_queue, r};
  endtask

  function automatic logic [IN_W-1:0] pack_tick(tick_t t);
    logic [IN_W-1:0] v;
    v = '0;
    v[0*DW +: DW] = t.lin_speed;  v[1*DW +: DW] = t.ang_speed;
    v[2*DW +: DW] = t.push_force; v[3*DW +: DW] = t.twist_torque;
    v[4*DW +: DW] = t.ref_lin;    v[5*DW +: DW] = t.ref_ang;
    v[6*DW +: DW] = t.lin_mass;   v[7*DW +: DW] = t.lin_damp;
    v[8*DW +: DW] = t.ang_mass;   v[9*DW +: DW] = t.ang_damp;
    v[10*DW] = t.adapt_on;
    return v;
  endfunction

  // tvalid stays high from one transfer to the next unless a gap is taken
  task automatic send_tick(tick_t t);
    if (tx_gap_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_tick(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    estimate_update(t);
    @(negedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (est_queue.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_tdata);
      end else begin
        logic [OUT_W-1:0] e;
        e = est_queue.pop_front();
        for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++)
          if (e[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W] !==
              out_tdata[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W]) begin
            errors++;
            $display("%0t est_p%0d expected %h actual %h", $time, i + 1,
                     e[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W],
                     out_tdata[i*adpu_pkg::PARAM_W +: adpu_pkg::PARAM_W]);
          end
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_off = 3000;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off = hold_off - 1;
    end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      hold_off = $urandom_range(0, 12);
    end else out_tready <= 1'b1;
  end

  task automatic drain;
    in_tvalid <= 1'b0;
    while (est_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [adpu_pkg::IDX_W-1:0] idx, logic [adpu_pkg::PARAM_W-1:0] val);
    cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < adpu_pkg::NUM_PARAMS) nom[idx] = longint'(signed'(val));
    else if (idx == adpu_pkg::REG_ADAPT_GAIN) gain_q = val[adpu_pkg::GAIN_W-1:0];
    else leak_q = val[adpu_pkg::GAIN_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic signed [DW-1:0] rnd_speed();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 300) - 150;
      default: return $signed($urandom_range(0, 393216)) - 196608;
    endcase
  endfunction

  function automatic tick_t rnd_tick();
    tick_t t;
    t.lin_speed = rnd_speed(); t.ang_speed = rnd_speed();
    t.push_force = $urandom_range(0, 9) == 0 ? $urandom()
                                             : $signed($urandom_range(0, 1310720)) - 655360;
    t.twist_torque = $urandom_range(0, 9) == 0 ? $urandom()
                                               : $signed($urandom_range(0, 1310720)) - 655360;
    t.ref_lin = $urandom_range(0, 3) == 0 ? t.lin_speed + $signed($urandom_range(0, 1400)) - 700
                                          : rnd_speed();
    t.ref_ang = $urandom_range(0, 3) == 0 ? t.ang_speed + $signed($urandom_range(0, 1400)) - 700
                                          : rnd_speed();
    t.lin_mass = $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(60, 1000000);
    t.ang_mass = $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(60, 1000000);
    t.lin_damp = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 655360);
    t.ang_damp = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 655360);
    t.adapt_on = $urandom_range(0, 9) != 0;
    return t;
  endfunction

  task automatic test_directed;
    tick_t t;
    logic signed [DW-1:0] ext[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1};
    t = '{default: 0};
    t.lin_mass = 65536; t.ang_mass = 65536; t.adapt_on = 1'b0;
    send_tick(t);                                   // disabled
    t.adapt_on = 1'b1; t.ref_lin = 327; t.ref_ang = -655;
    send_tick(t);                                   // deadzone edge
    t.ref_lin = 328; send_tick(t);
    t.ref_lin = 0; t.ref_ang = 656; send_tick(t);
    t.lin_mass = 65; send_tick(t);                  // small mass
    t.adapt_on = 1'b0; send_tick(t);                // enable change without result
    t.lin_mass = 66; t.ang_mass = 65; t.adapt_on = 1'b1; send_tick(t);
    t.ang_mass = 66; send_tick(t);
    t.ang_mass = 32'sh8000_0000; send_tick(t);
    for (int i = 0; i < 4; i++) begin
      t.lin_speed = ext[i]; t.ang_speed = ext[3 - i]; t.push_force = ext[i];
      t.twist_torque = ext[(i + 1) % 4]; t.ref_lin = ext[(i + 2) % 4];
      t.ref_ang = ext[3 - i]; t.lin_mass = 66 + i * 1000; t.ang_mass = 32'sh7fff_ffff;
      t.lin_damp = ext[i]; t.ang_damp = ext[(i + 3) % 4];
      send_tick(t);
    end
    t.lin_speed = 196608; t.ref_lin = 0; t.ang_speed = 0; t.ref_ang = 300000;
    t.lin_mass = 66; t.ang_mass = 66;
    send_tick(t);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_tick(rnd_tick());
    drain();
  endtask

  task automatic test_config;
    logic [adpu_pkg::PARAM_W-1:0] v;
    for (int i = 0; i < adpu_pkg::NUM_PARAMS; i++) begin
      v = 48'({$urandom(), $urandom()});
      write_reg(REG_NOM_P1 + adpu_pkg::IDX_W'(i),
                i == 0 ? 48'h8000_0000_0000 : i == 1 ? 48'h7fff_ffff_ffff : v);
    end
    write_reg(adpu_pkg::REG_ADAPT_GAIN, 48'hffff_ffff_ffff);
    write_reg(adpu_pkg::REG_LEAK_GAIN, 48'h0);
    test_random(150);
    write_reg(adpu_pkg::REG_ADAPT_GAIN, 48'h0);
    write_reg(adpu_pkg::REG_LEAK_GAIN, 48'hffff_ffff_ffff);
    test_random(100);
    write_reg(adpu_pkg::REG_ADAPT_GAIN, 48'({$urandom(), $urandom()}));
    write_reg(adpu_pkg::REG_LEAK_GAIN, 48'({$urandom(), $urandom()} >> 8));
    test_random(150);
    write_reg(adpu_pkg::REG_ADAPT_GAIN, 48'(adpu_pkg::GAIN_RST) << 4);
    write_reg(adpu_pkg::REG_LEAK_GAIN, 48'(adpu_pkg::LEAK_RST));
  endtask

  task automatic test_backpressure;
    long_hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_tick(rnd_tick());
    drain();
    tx_gap_en = 1'b0;
    for (int i = 0; i < 20; i++) send_tick(rnd_tick());
    drain();
  endtask

  initial begin
    nom = '{adpu_pkg::NOM_P1_RST, adpu_pkg::NOM_P2_RST, adpu_pkg::NOM_P3_RST,
            adpu_pkg::NOM_P4_RST, adpu_pkg::NOM_P5_RST, adpu_pkg::NOM_P6_RST};
    est = nom;
    gain_q = adpu_pkg::GAIN_RST;
    leak_q = adpu_pkg::LEAK_RST;
    prev_en = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(170);
    test_config();
    test_random(250);
    test_backpressure();
    rx_stall_en = 1'b0;
    tx_gap_en = 1'b0;
    test_random(180);
    if (errors == 0) $display("tb_adaptive_dynamic_param_update_top: clean");
    else $display("tb_adaptive_dynamic_param_update_top: errors");
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_adaptive_dynamic_param_update_top: errors");
    $finish;
  end

endmodule

>>> sim.f
design/adpu_pkg.sv
design/adpu_mul.sv
design/adpu_div.sv
design/adaptive_dynamic_param_update_top.sv
dv/tb_adaptive_dynamic_param_update_top.sv
